// ===== hw/rtl/bitmap_block_allocator_unit_defines.svh =====
// Assertion macros for the bitmap block allocator.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef BITMAP_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define BBA_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define BBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/bba_pkg.sv =====
// Shared constants, codes, types and count helpers of the bitmap block allocator.
// No dependencies.
`default_nettype none

package bba_pkg;

   // Geometry
   localparam int MAX_BLOCKS  = 4096;
   localparam int BLOCK_BYTES = 4096;
   localparam int WORD_BITS   = 64;
   localparam int MAP_WORDS   = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int IDX_W       = $clog2(MAX_BLOCKS);
   localparam int BIT_W       = $clog2(WORD_BITS);
   localparam int WI_W        = $clog2(MAP_WORDS);
   localparam int OFS_W       = $clog2(BLOCK_BYTES);
   localparam int OCT_BITS    = 8;
   localparam int OCT_W       = $clog2(OCT_BITS);

   // Field widths
   localparam int KIND_W = 2;
   localparam int ADDR_W = 24;
   localparam int BLK_W  = 13;
   localparam int LEN_W  = 25;
   localparam int STAT_W = 3;

   // Operation codes
   localparam logic [KIND_W-1:0] KIND_INIT  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FREE  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_MARK  = 2'd3;

   // Status codes
   localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
   localparam logic [STAT_W-1:0] ST_NOINIT  = 3'd1;
   localparam logic [STAT_W-1:0] ST_ZERO    = 3'd2;
   localparam logic [STAT_W-1:0] ST_NOSPACE = 3'd3;
   localparam logic [STAT_W-1:0] ST_REJECT  = 3'd4;
   localparam logic [STAT_W-1:0] ST_IGNORED = 3'd5;

   // Decode outcome
   localparam logic [1:0] ACT_DONE  = 2'd0;
   localparam logic [1:0] ACT_SCAN  = 2'd1;
   localparam logic [1:0] ACT_RANGE = 2'd2;

   typedef struct packed {
      logic load;
      logic decode;
      logic scan_read;
      logic scan_step;
      logic upd_read;
      logic upd_write;
   } bba_cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       scan_hit;
      logic       scan_stop;
      logic       octet_last;
      logic       last_word;
   } bba_sts_type;

   // Add with saturation at the total
   function automatic logic [BLK_W-1:0] sat_add(input logic [BLK_W-1:0] used,
                                                input logic [BLK_W-1:0] n,
                                                input logic [BLK_W-1:0] total);
      logic [BLK_W:0] sum;
      sum = {1'b0, used} + {1'b0, n};
      return (sum > {1'b0, total}) ? total : sum[BLK_W-1:0];
   endfunction

   // Subtract with saturation at zero
   function automatic logic [BLK_W-1:0] sat_sub(input logic [BLK_W-1:0] used,
                                                input logic [BLK_W-1:0] n);
      return (n > used) ? '0 : used - n;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bba_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bba_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/bba_ctrl.sv =====
// Sequencer of the bitmap block allocator: accept, decode, scan, update, respond.
// Depends on bba_pkg.
`default_nettype none

module bba_ctrl import bba_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   output logic        rsp_valid,
   output bba_cmd_type cmd,
   input  bba_sts_type sts
);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_DECODE    = 3'd1;
   localparam logic [2:0] S_SCAN_RD   = 3'd2;
   localparam logic [2:0] S_SCAN_BITS = 3'd3;
   localparam logic [2:0] S_UPD_RD    = 3'd4;
   localparam logic [2:0] S_UPD_WR    = 3'd5;
   localparam logic [2:0] S_RESP      = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // Next state and commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            case (sts.action)
               ACT_SCAN:  state_in = S_SCAN_RD;
               ACT_RANGE: state_in = S_UPD_RD;
               default:   state_in = S_RESP;
            endcase
         end
         S_SCAN_RD: begin
            cmd.scan_read = 1'b1;
            state_in      = S_SCAN_BITS;
         end
         S_SCAN_BITS: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_hit) begin
               state_in = S_UPD_RD;
            end else if (sts.scan_stop) begin
               state_in = S_RESP;
            end else if (sts.octet_last) begin
               state_in = S_SCAN_RD;
            end
         end
         S_UPD_RD: begin
            cmd.upd_read = 1'b1;
            state_in     = S_UPD_WR;
         end
         S_UPD_WR: begin
            cmd.upd_write = 1'b1;
            state_in      = sts.last_word ? S_RESP : S_UPD_RD;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

endmodule

`default_nettype wire

// ===== hw/rtl/bba_dp.sv =====
// Datapath of the bitmap block allocator: request registers, counts, hint,
// scan unit, word update and the used-bit map RAM. Depends on bba_pkg, bba_ram.
`default_nettype none

module bba_dp import bba_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  bba_cmd_type       cmd,
   output bba_sts_type       sts,
   input  logic              csr_we,
   input  logic [BLK_W-1:0]  csr_wdata,
   input  logic [KIND_W-1:0] req_kind,
   input  logic [ADDR_W-1:0] req_address,
   input  logic [BLK_W-1:0]  req_block_count,
   input  logic [LEN_W-1:0]  req_length_bytes,
   input  logic              req_mark_used,
   output logic [STAT_W-1:0] rsp_status,
   output logic [ADDR_W-1:0] rsp_alloc_address,
   output logic [BLK_W-1:0]  rsp_used_count,
   output logic [BLK_W-1:0]  rsp_free_blocks,
   output logic              rsp_ready_res
);

   // Control state
   logic [BLK_W-1:0]     total_ff;
   logic [BLK_W-1:0]     used_ff;
   logic [BLK_W-1:0]     hint_ff;
   logic                 init_ff;
   logic [MAP_WORDS-1:0] valid_ff;

   // Request and work registers
   logic [KIND_W-1:0] kind_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [BLK_W-1:0]  count_ff;
   logic [LEN_W-1:0]  len_ff;
   logic              mark_ff;
   logic [STAT_W-1:0] status_ff;
   logic [ADDR_W-1:0] addr_out_ff;
   logic [BLK_W-1:0]  pos_ff;
   logic [BLK_W-1:0]  run_ff;
   logic [BLK_W-1:0]  lo_ff;
   logic [BLK_W-1:0]  hi_ff;
   logic              set_ff;
   logic [WI_W-1:0]   wi_ff;
   logic [WI_W-1:0]   last_w_ff;
   logic              valid_rd_ff;

   logic [BLK_W-1:0] total_eff;

   // Decode signals
   logic [BLK_W-1:0]  fr_start;
   logic [BLK_W:0]    fr_end;
   logic [OFS_W-1:0]  mk_ofs;
   logic [BLK_W-1:0]  mk_start;
   logic [BLK_W-1:0]  mk_skip;
   logic [LEN_W-1:0]  mk_diff;
   logic [BLK_W-1:0]  mk_n_raw;
   logic [BLK_W-1:0]  mk_room;
   logic [BLK_W-1:0]  mk_n;
   logic [1:0]        dec_action;
   logic [STAT_W-1:0] dec_status;
   logic [BLK_W-1:0]  dec_lo;
   logic [BLK_W-1:0]  dec_hi;
   logic              dec_set;
   logic [BLK_W-1:0]  dec_last;

   // Scan signals
   logic [WORD_BITS-1:0] word_q;
   logic [BLK_W-1:0]     run;
   logic                 found;
   logic                 stop;
   logic [BLK_W-1:0]     hit_i;
   logic [BLK_W-1:0]     hit_first;
   logic [BLK_W-1:0]     hit_end;

   // Update signals
   logic [WORD_BITS-1:0] upd_mask;
   logic [WORD_BITS-1:0] upd_word;

   logic [WI_W-1:0]      ram_rd_addr;
   logic [WORD_BITS-1:0] ram_rd_data;

   assign total_eff = (total_ff > BLK_W'(MAX_BLOCKS)) ? BLK_W'(MAX_BLOCKS) : total_ff;

   // Free: run start and end in blocks
   assign fr_start = BLK_W'(addr_ff[ADDR_W-1:OFS_W]);
   assign fr_end   = {1'b0, fr_start} + {1'b0, count_ff};

   // Mark: round base up, drop the skipped bytes, clip at the total
   assign mk_ofs   = addr_ff[OFS_W-1:0];
   assign mk_start = BLK_W'(addr_ff[ADDR_W-1:OFS_W]) + BLK_W'(mk_ofs != '0);
   assign mk_skip  = (mk_ofs == '0) ? '0 : BLK_W'(BLOCK_BYTES) - BLK_W'(mk_ofs);
   assign mk_diff  = len_ff - LEN_W'(mk_skip);
   assign mk_n_raw = (len_ff > LEN_W'(mk_skip)) ? BLK_W'(mk_diff >> OFS_W) : '0;
   assign mk_room  = total_eff - mk_start;
   assign mk_n     = (mk_start >= total_eff) ? '0 :
                     ((mk_n_raw > mk_room) ? mk_room : mk_n_raw);

   // Classify the captured request
   always_comb begin
      dec_action = ACT_DONE;
      dec_status = ST_OK;
      dec_lo     = '0;
      dec_hi     = '0;
      dec_set    = 1'b0;
      case (kind_ff)
         KIND_INIT: begin
            dec_status = init_ff ? ST_IGNORED : ST_OK;
         end
         KIND_ALLOC: begin
            if (!init_ff) begin
               dec_status = ST_NOINIT;
            end else if (count_ff == '0) begin
               dec_status = ST_ZERO;
            end else begin
               dec_status = ST_NOSPACE;
               dec_action = ACT_SCAN;
            end
         end
         KIND_FREE: begin
            if (!init_ff) begin
               dec_status = ST_NOINIT;
            end else if (count_ff == '0) begin
               dec_status = ST_ZERO;
            end else if (addr_ff == '0 || fr_end > {1'b0, total_eff}) begin
               dec_status = ST_REJECT;
            end else begin
               dec_action = ACT_RANGE;
               dec_lo     = fr_start;
               dec_hi     = fr_end[BLK_W-1:0];
            end
         end
         default: begin
            dec_lo     = mk_start;
            dec_hi     = mk_start + mk_n;
            dec_set    = mark_ff;
            dec_action = (mk_n != '0) ? ACT_RANGE : ACT_DONE;
         end
      endcase
   end

   assign dec_last = dec_hi - BLK_W'(1);

   // Walk one octet of the fetched word from the scan position
   assign word_q = valid_rd_ff ? ram_rd_data : '1;

   always_comb begin
      run   = run_ff;
      found = 1'b0;
      stop  = 1'b0;
      hit_i = '0;
      for (int k = 0; k < OCT_BITS; k++) begin
         if (!found && !stop) begin
            if (pos_ff + BLK_W'(k) >= total_eff) begin
               stop = 1'b1;
            end else if (pos_ff + BLK_W'(k) >= hint_ff) begin
               if (!word_q[{pos_ff[BIT_W-1:OCT_W], OCT_W'(k)}]) begin
                  run = run + BLK_W'(1);
                  if (run == count_ff) begin
                     found = 1'b1;
                     hit_i = pos_ff + BLK_W'(k);
                  end
               end else begin
                  run = '0;
               end
            end
         end
      end
   end

   assign hit_end   = hit_i + BLK_W'(1);
   assign hit_first = hit_end - count_ff;

   // Set or clear the bits of the current word inside [lo, hi)
   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         upd_mask[b] = ({1'b0, wi_ff, BIT_W'(b)} >= lo_ff) &&
                       ({1'b0, wi_ff, BIT_W'(b)} < hi_ff);
      end
   end

   assign upd_word = set_ff ? (word_q | upd_mask) : (word_q & ~upd_mask);

   // Status to the sequencer
   assign sts.action     = dec_action;
   assign sts.scan_hit   = found;
   assign sts.scan_stop  = stop;
   assign sts.octet_last = (pos_ff[BIT_W-1:OCT_W] == '1);
   assign sts.last_word  = (wi_ff == last_w_ff);

   // Map RAM
   assign ram_rd_addr = cmd.scan_read ? pos_ff[IDX_W-1:BIT_W] : wi_ff;

   bba_ram #(
      .WIDTH(WORD_BITS),
      .DEPTH(MAP_WORDS)
   ) u_map (
      .clock  (clock),
      .wr_en  (cmd.upd_write),
      .wr_addr(wi_ff),
      .wr_data(upd_word),
      .rd_en  (cmd.scan_read | cmd.upd_read),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // Control state: config, counts, hint, init flag, word valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= BLK_W'(4096);
         used_ff  <= '0;
         hint_ff  <= '0;
         init_ff  <= 1'b0;
         valid_ff <= '0;
      end else begin
         if (csr_we) begin
            total_ff <= csr_wdata;
         end
         if (cmd.decode) begin
            case (kind_ff)
               KIND_INIT: begin
                  if (!init_ff) begin
                     valid_ff <= '0;
                     used_ff  <= total_eff;
                     hint_ff  <= '0;
                     init_ff  <= 1'b1;
                  end
               end
               KIND_FREE: begin
                  if (dec_action == ACT_RANGE) begin
                     used_ff <= sat_sub(used_ff, count_ff);
                     if (fr_start < hint_ff) begin
                        hint_ff <= fr_start;
                     end
                  end
               end
               KIND_MARK: begin
                  used_ff <= mark_ff ? sat_add(used_ff, mk_n, total_eff)
                                     : sat_sub(used_ff, mk_n);
               end
               default: begin
               end
            endcase
         end
         if (cmd.scan_step && found) begin
            used_ff <= sat_add(used_ff, count_ff, total_eff);
            hint_ff <= hit_end;
         end
         if (cmd.upd_write) begin
            valid_ff[wi_ff] <= 1'b1;
         end
      end
   end

   // Request capture and work registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= req_kind;
         addr_ff  <= req_address;
         count_ff <= req_block_count;
         len_ff   <= req_length_bytes;
         mark_ff  <= req_mark_used;
      end
      if (cmd.decode) begin
         status_ff   <= dec_status;
         addr_out_ff <= '0;
         lo_ff       <= dec_lo;
         hi_ff       <= dec_hi;
         set_ff      <= dec_set;
         wi_ff       <= dec_lo[IDX_W-1:BIT_W];
         last_w_ff   <= dec_last[IDX_W-1:BIT_W];
         pos_ff      <= {hint_ff[BLK_W-1:OCT_W], {OCT_W{1'b0}}};
         run_ff      <= '0;
      end
      if (cmd.scan_read || cmd.upd_read) begin
         valid_rd_ff <= valid_ff[ram_rd_addr];
      end
      if (cmd.scan_step) begin
         if (found) begin
            status_ff   <= ST_OK;
            addr_out_ff <= ADDR_W'({hit_first[IDX_W-1:0], {OFS_W{1'b0}}});
            lo_ff       <= hit_first;
            hi_ff       <= hit_end;
            set_ff      <= 1'b1;
            wi_ff       <= hit_first[IDX_W-1:BIT_W];
            last_w_ff   <= hit_i[IDX_W-1:BIT_W];
         end else begin
            run_ff <= run;
            pos_ff <= pos_ff + BLK_W'(OCT_BITS);
         end
      end
      if (cmd.upd_write) begin
         wi_ff <= wi_ff + WI_W'(1);
      end
   end

   // Result fields
   assign rsp_status        = status_ff;
   assign rsp_alloc_address = addr_out_ff;
   assign rsp_used_count    = used_ff;
   assign rsp_free_blocks   = (total_eff > used_ff) ? total_eff - used_ff : '0;
   assign rsp_ready_res     = init_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/bitmap_block_allocator_unit.sv =====
// Bitmap block allocator: one request in flight, result strobed for one
// cycle on rsp_valid; the receiver cannot stall it. busy rises the cycle
// after start is taken and falls after the result cycle; a request passes
// at least through accept, decode and result. Allocation scans the map
// eight blocks per cycle plus one RAM read per 64-block word, from the
// hint to the hit or the total. Any map change (allocate, free, mark)
// does a read-modify-write of each touched word, a map RAM read
// followed by a write. After reset every map word reads as used through
// per-word valid bits, so no clearing pass is needed.
// Depends on bba_pkg, bba_ctrl, bba_dp and the assertion macro header.
`default_nettype none
`include "bitmap_block_allocator_unit_defines.svh"

module bitmap_block_allocator_unit import bba_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [KIND_W-1:0] req_kind,
   input  logic [ADDR_W-1:0] req_address,
   input  logic [BLK_W-1:0]  req_block_count,
   input  logic [LEN_W-1:0]  req_length_bytes,
   input  logic              req_mark_used,
   output logic              rsp_valid,
   output logic [STAT_W-1:0] rsp_status,
   output logic [ADDR_W-1:0] rsp_alloc_address,
   output logic [BLK_W-1:0]  rsp_used_count,
   output logic [BLK_W-1:0]  rsp_free_blocks,
   output logic              rsp_ready_res,
   input  logic              csr_we,
   input  logic [BLK_W-1:0]  csr_wdata
);

   bba_cmd_type cmd;
   bba_sts_type sts;

   bba_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .rsp_valid(rsp_valid),
      .cmd      (cmd),
      .sts      (sts)
   );

   bba_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_kind         (req_kind),
      .req_address      (req_address),
      .req_block_count  (req_block_count),
      .req_length_bytes (req_length_bytes),
      .req_mark_used    (req_mark_used),
      .rsp_status       (rsp_status),
      .rsp_alloc_address(rsp_alloc_address),
      .rsp_used_count   (rsp_used_count),
      .rsp_free_blocks  (rsp_free_blocks),
      .rsp_ready_res    (rsp_ready_res)
   );

   // Result only while a request is in flight, for one cycle, after acceptance
   `BBA_ASSERT_IMPLIES(a_rsp_in_flight, clock, reset, rsp_valid, busy, "result outside a request")
   `BBA_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "result strobe too long")
   `BBA_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy && !rsp_valid, "accept slip")

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the bitmap block allocator unit.
// Depends on bba_pkg and the bitmap_block_allocator_unit RTL.
`timescale 1ns / 1ps

module testbench import bba_pkg::*; ();

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [ADDR_W-1:0] alloc_address;
      logic [BLK_W-1:0]  used_count;
      logic [BLK_W-1:0]  free_blocks;
      logic              ready_res;
   } alloc_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [KIND_W-1:0] req_kind = KIND_INIT;
   logic [ADDR_W-1:0] req_address = '0;
   logic [BLK_W-1:0]  req_block_count = '0;
   logic [LEN_W-1:0]  req_length_bytes = '0;
   logic              req_mark_used = 1'b0;
   logic              rsp_valid;
   logic [STAT_W-1:0] rsp_status;
   logic [ADDR_W-1:0] rsp_alloc_address;
   logic [BLK_W-1:0]  rsp_used_count;
   logic [BLK_W-1:0]  rsp_free_blocks;
   logic              rsp_ready_res;
   logic              csr_we = 1'b0;
   logic [BLK_W-1:0]  csr_wdata = '0;

   bitmap_block_allocator_unit uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_address(req_address),
      .req_block_count(req_block_count), .req_length_bytes(req_length_bytes),
      .req_mark_used(req_mark_used), .rsp_valid(rsp_valid),
      .rsp_status(rsp_status), .rsp_alloc_address(rsp_alloc_address),
      .rsp_used_count(rsp_used_count), .rsp_free_blocks(rsp_free_blocks),
      .rsp_ready_res(rsp_ready_res), .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // Allocator mirror
   bit               block_busy [0:MAX_BLOCKS-1];
   int unsigned      used_count_m;
   int unsigned      next_fit_hint;
   bit               ready_m;
   int unsigned      total_setting;
   alloc_result_type pending_results [$];
   int unsigned      granted_addrs [$];

   int unsigned   error_count;
   int unsigned   request_count;
   int unsigned   grant_count;
   int unsigned   setting_count;
   bit            gaps_on;

   function automatic int unsigned effective_total();
      return (total_setting > MAX_BLOCKS) ? MAX_BLOCKS : total_setting;
   endfunction

   function automatic void add_used(input longint unsigned n);
      longint unsigned t;
      t = effective_total();
      used_count_m = (used_count_m + n > t) ? 32'(t) : 32'(used_count_m + n);
   endfunction

   function automatic void drop_used(input longint unsigned n);
      used_count_m = (n > used_count_m) ? 0 : 32'(used_count_m - n);
   endfunction

   // Apply one request to the mirror and queue the result it must produce
   function automatic void predict_request(input logic [KIND_W-1:0] kind,
                                           input logic [ADDR_W-1:0] addr,
                                           input logic [BLK_W-1:0] cnt,
                                           input logic [LEN_W-1:0] len,
                                           input logic mark_used);
      alloc_result_type r;
      longint unsigned  tot, run, first, base, abase, skip, n, i;
      bit               found;
      tot = effective_total();
      r = '0;
      r.status = ST_OK;
      case (kind)
         KIND_INIT: begin
            if (ready_m) begin
               r.status = ST_IGNORED;
            end else begin
               foreach (block_busy[k]) block_busy[k] = 1'b1;
               used_count_m = 32'(tot);
               next_fit_hint = 0;
               ready_m = 1'b1;
            end
         end
         KIND_ALLOC: begin
            if (!ready_m) r.status = ST_NOINIT;
            else if (cnt == 0) r.status = ST_ZERO;
            else begin
               r.status = ST_NOSPACE;
               run = 0;
               found = 1'b0;
               for (i = next_fit_hint; i < tot && !found; i++) begin
                  if (!block_busy[i]) begin
                     run++;
                     if (run == cnt) begin
                        first = i + 1 - cnt;
                        for (longint unsigned j = first; j <= i; j++) block_busy[j] = 1'b1;
                        add_used(cnt);
                        next_fit_hint = 32'((i + 1) & 13'h1FFF);
                        r.alloc_address = ADDR_W'(first * BLOCK_BYTES);
                        r.status = ST_OK;
                        found = 1'b1;
                     end
                  end else begin
                     run = 0;
                  end
               end
            end
         end
         KIND_FREE: begin
            if (!ready_m) r.status = ST_NOINIT;
            else if (cnt == 0) r.status = ST_ZERO;
            else if (addr == 0) r.status = ST_REJECT;
            else begin
               base = addr / BLOCK_BYTES;
               if (base + cnt > tot) begin
                  r.status = ST_REJECT;
               end else begin
                  for (i = base; i < base + cnt; i++) block_busy[i] = 1'b0;
                  drop_used(cnt);
                  if (base < next_fit_hint) next_fit_hint = 32'(base);
               end
            end
         end
         default: begin
            // Round the base up to a block, clip the run at the total
            abase = ((longint'(addr) + BLOCK_BYTES - 1) / BLOCK_BYTES) * BLOCK_BYTES;
            skip = abase - addr;
            n = (len > skip) ? (len - skip) / BLOCK_BYTES : 0;
            base = abase / BLOCK_BYTES;
            if (base >= tot) n = 0;
            else if (n > tot - base) n = tot - base;
            for (i = base; i < base + n; i++) block_busy[i] = mark_used;
            if (mark_used) add_used(n);
            else drop_used(n);
         end
      endcase
      r.used_count = BLK_W'(used_count_m);
      r.free_blocks = (tot > used_count_m) ? BLK_W'(tot - used_count_m) : '0;
      r.ready_res = ready_m;
      if (kind == KIND_ALLOC && r.status == ST_OK) begin
         grant_count++;
         granted_addrs.push_back(32'(r.alloc_address));
      end
      pending_results.push_back(r);
   endfunction

   // Compare each strobed result with the oldest expectation
   always @(posedge clock) begin
      alloc_result_type want, got;
      if (!reset && rsp_valid) begin
         got = {rsp_status, rsp_alloc_address, rsp_used_count, rsp_free_blocks,
                rsp_ready_res};
         if (pending_results.size() == 0) begin
            error_count++;
            if (error_count <= 10) $display("ERROR: result with none expected: %p", got);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               error_count++;
               if (error_count <= 10)
                  $display("ERROR: st %0d/%0d addr %h/%h used %0d/%0d free %0d/%0d rdy %0d/%0d",
                           want.status, got.status, want.alloc_address,
                           got.alloc_address, want.used_count, got.used_count,
                           want.free_blocks, got.free_blocks, want.ready_res,
                           got.ready_res);
            end
         end
      end
   end

   // Send one request; called and returns at a falling edge
   task automatic send_request(input logic [KIND_W-1:0] kind,
                               input logic [ADDR_W-1:0] addr,
                               input logic [BLK_W-1:0] cnt,
                               input logic [LEN_W-1:0] len,
                               input logic mark_used);
      if (gaps_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 8)) @(negedge clock);
      while (busy) @(negedge clock);
      req_kind = kind;
      req_address = addr;
      req_block_count = cnt;
      req_length_bytes = len;
      req_mark_used = mark_used;
      start = 1'b1;
      predict_request(kind, addr, cnt, len, mark_used);
      request_count++;
      @(negedge clock);
      start = 1'b0;
   endtask

   // Write the block total once the block has drained
   task automatic write_total(input logic [BLK_W-1:0] value);
      while (pending_results.size() != 0 || busy) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_we = 1'b1;
      csr_wdata = value;
      total_setting = 32'(value);
      setting_count++;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic test_before_init();
      send_request(KIND_ALLOC, 24'h0, 13'd1, '0, 1'b0);
      send_request(KIND_FREE, 24'h1000, 13'd1, '0, 1'b0);
      // mark works without init
      send_request(KIND_MARK, 24'h0, '0, 25'h1FFFFFF, 1'b0);
      send_request(KIND_MARK, 24'h1, '0, 25'h3000, 1'b1);
   endtask

   task automatic test_directed();
      send_request(KIND_INIT, 24'hFFFFFF, 13'h1FFF, 25'h1FFFFFF, 1'b1);
      send_request(KIND_INIT, '0, '0, '0, 1'b0);
      send_request(KIND_ALLOC, '0, 13'd1, '0, 1'b0);
      send_request(KIND_MARK, 24'h0, '0, 25'h1000000, 1'b0);
      send_request(KIND_ALLOC, '0, 13'd0, '0, 1'b0);
      send_request(KIND_ALLOC, '0, 13'd4096, '0, 1'b0);
      send_request(KIND_ALLOC, '0, 13'd1, '0, 1'b0);
      send_request(KIND_ALLOC, '0, 13'h1FFF, '0, 1'b0);
      send_request(KIND_FREE, 24'h0, 13'd1, '0, 1'b0);
      send_request(KIND_FREE, 24'h1000, 13'd0, '0, 1'b0);
      send_request(KIND_FREE, 24'hFFF000, 13'd2, '0, 1'b0);
      send_request(KIND_FREE, 24'h5000, 13'd3, '0, 1'b0);
      send_request(KIND_FREE, 24'h000FFF, 13'd1, '0, 1'b0);
      send_request(KIND_MARK, 24'h0801, '0, 25'h0FFF, 1'b1);
      send_request(KIND_MARK, 24'hFFFFFF, '0, 25'h1FFFFFF, 1'b1);
      send_request(KIND_MARK, 24'hFFE000, '0, 25'h1FFFFFF, 1'b1);
      send_request(KIND_MARK, 24'h0, '0, 25'h1FFFFFF, 1'b1);
      send_request(KIND_FREE, 24'hFFFFFF, 13'd1, '0, 1'b0);
      send_request(KIND_ALLOC, '0, 13'd1, '0, 1'b0);
   endtask

   task automatic test_hint_past_total();
      send_request(KIND_MARK, 24'h0, '0, 25'h1000000, 1'b0);
      send_request(KIND_ALLOC, '0, 13'd200, '0, 1'b0);
      write_total(13'd100);
      send_request(KIND_ALLOC, '0, 13'd1, '0, 1'b0);
      send_request(KIND_MARK, 24'h0, '0, 25'h1000000, 1'b1);
      write_total(13'd8191);
      send_request(KIND_MARK, 24'h0, '0, 25'h1000000, 1'b0);
      send_request(KIND_ALLOC, '0, 13'd4096, '0, 1'b0);
   endtask

   // Random phase: mostly allocations and frees over a cleared map, plus marks and inits
   task automatic test_random_phase(input logic [BLK_W-1:0] total, input int items);
      logic [ADDR_W-1:0] a;
      logic [BLK_W-1:0]  c;
      logic [LEN_W-1:0]  l;
      int                pick;
      write_total(total);
      send_request(KIND_MARK, 24'h0, '0, 25'h1000000, 1'b0);
      repeat (items) begin
         pick = int'($urandom_range(0, 99));
         if (pick < 40) begin
            c = ($urandom_range(0, 9) == 0) ? BLK_W'($urandom) : BLK_W'($urandom_range(1, 12));
            send_request(KIND_ALLOC, ADDR_W'($urandom), c, LEN_W'($urandom), 1'($urandom));
         end else if (pick < 65) begin
            if (granted_addrs.size() != 0 && $urandom_range(0, 2) != 0) begin
               a = ADDR_W'(granted_addrs[$urandom_range(0, granted_addrs.size() - 1)]);
               a = a | ADDR_W'($urandom_range(0, 1) ? $urandom_range(0, 4095) : 0);
               c = BLK_W'($urandom_range(1, 12));
            end else begin
               a = ADDR_W'($urandom);
               c = $urandom_range(0, 1) ? BLK_W'($urandom) : BLK_W'($urandom_range(0, 40));
            end
            send_request(KIND_FREE, a, c, LEN_W'($urandom), 1'($urandom));
         end else if (pick < 95) begin
            if ($urandom_range(0, 3) == 0) begin
               a = ADDR_W'($urandom);
               l = LEN_W'($urandom);
            end else begin
               a = ADDR_W'($urandom_range(0, 4095) * BLOCK_BYTES + $urandom_range(0, 2) * 2047);
               l = LEN_W'($urandom_range(0, 64) * BLOCK_BYTES + $urandom_range(0, 4095));
            end
            send_request(KIND_MARK, a, BLK_W'($urandom), l, 1'($urandom));
         end else begin
            send_request(KIND_INIT, ADDR_W'($urandom), BLK_W'($urandom), LEN_W'($urandom),
                         1'($urandom));
         end
      end
   endtask

   initial begin
      #(100_000_000);
      $display("FAIL bitmap_block_allocator_unit");
      $finish;
   end

   initial begin
      total_setting = 4096;
      foreach (block_busy[k]) block_busy[k] = 1'b1;
      used_count_m = 0;
      next_fit_hint = 0;
      ready_m = 1'b0;
      gaps_on = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_before_init();
      test_directed();
      test_hint_past_total();
      test_random_phase(13'd4096, 130);
      test_random_phase(13'd1, 60);
      test_random_phase(13'd64, 110);
      test_random_phase(13'd0, 40);
      test_random_phase(13'd777, 120);
      test_random_phase(13'd8191, 120);
      gaps_on = 1'b0;
      test_random_phase(13'd4096, 140);

      // Drain
      while (pending_results.size() != 0) @(negedge clock);
      repeat (1000) @(negedge clock);
      $display("Ran %0d requests over %0d block-total settings; %0d allocations granted.",
               request_count, setting_count, grant_count);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("PASS bitmap_block_allocator_unit");
      end else begin
         $display("Mismatches: %0d, results missing: %0d", error_count,
                  pending_results.size());
         $display("FAIL bitmap_block_allocator_unit");
      end
      $finish;
   end

endmodule

// ===== bitmap_block_allocator_unit.f =====
+incdir+hw/rtl
hw/rtl/bba_pkg.sv
hw/rtl/bba_ram.sv
hw/rtl/bba_ctrl.sv
hw/rtl/bba_dp.sv
hw/rtl/bitmap_block_allocator_unit.sv
tb/testbench.sv
